[rtl/hcmm_pkg.sv]
// Constants, decode types and address helpers for the handheld console memory map.
`timescale 1ns / 1ps

package hcmm_pkg;

  localparam int unsigned AddrW     = 16;
  localparam int unsigned MemDepth  = 1 << AddrW;
  localparam int unsigned IoDepth   = 128;
  localparam int unsigned IoIdxW    = $clog2(IoDepth);
  localparam int unsigned DmaLength = 160;
  localparam logic [7:0]  DmaLast   = 8'(DmaLength - 1);

  localparam logic [1:0] ReqRead    = 2'd0;
  localparam logic [1:0] ReqWrite   = 2'd1;
  localparam logic [1:0] ReqPreload = 2'd2;

  localparam logic [15:0] EchoLo   = 16'hE000;
  localparam logic [15:0] EchoHi   = 16'hFDFF;
  localparam logic [15:0] EchoOfs  = 16'h2000;
  localparam logic [15:0] RomHi    = 16'h7FFF;
  localparam logic [15:0] OamHi    = 16'hFEFF;
  localparam logic [15:0] IoHi     = 16'hFF7F;
  localparam logic [15:0] HramLo   = 16'hFF80;
  localparam logic [15:0] HramHi   = 16'hFFFE;
  localparam logic [15:0] AdJoyp   = 16'hFF00;
  localparam logic [15:0] AdRnd    = 16'hFF04;
  localparam logic [15:0] AdIf     = 16'hFF0F;
  localparam logic [15:0] AdLcd    = 16'hFF40;
  localparam logic [15:0] AdScy    = 16'hFF42;
  localparam logic [15:0] AdScx    = 16'hFF43;
  localparam logic [15:0] AdLine   = 16'hFF44;
  localparam logic [15:0] AdDma    = 16'hFF46;
  localparam logic [15:0] AdPalLo  = 16'hFF47;
  localparam logic [15:0] AdPalHi  = 16'hFF49;
  localparam logic [7:0]  OamPage  = 8'hFE;

  localparam logic [7:0] JoypTop  = 8'hC0;
  localparam logic [7:0] JoypDirs = 8'h10;
  localparam logic [7:0] JoypBtns = 8'h20;

  typedef enum logic [3:0] {
    RG_MEM, RG_IO, RG_RND, RG_LCD, RG_SCY, RG_SCX, RG_LINE, RG_JOYP, RG_IF, RG_IE
  } rgn_e;

  typedef enum logic [3:0] {
    WR_NONE, WR_MEM, WR_IO, WR_LCD, WR_SCY, WR_SCX, WR_DMA, WR_IF, WR_IE
  } wr_e;

  // echo of work RAM folds onto work RAM; everything else sits at its bus address
  function automatic logic [15:0] phys_addr(input logic [15:0] a);
    if (a >= EchoLo && a <= EchoHi) return a - EchoOfs;
    return a;
  endfunction

  function automatic rgn_e rd_region(input logic [15:0] a);
    if (a <= OamHi)  return RG_MEM;
    if (a == AdRnd)  return RG_RND;
    if (a == AdLcd)  return RG_LCD;
    if (a == AdScy)  return RG_SCY;
    if (a == AdScx)  return RG_SCX;
    if (a == AdLine) return RG_LINE;
    if (a == AdJoyp) return RG_JOYP;
    if (a == AdIf)   return RG_IF;
    if (a <= IoHi)   return RG_IO;
    if (a <= HramHi) return RG_MEM;
    return RG_IE;
  endfunction

  function automatic wr_e wr_decode(input logic [15:0] a);
    if (a <= RomHi)                   return WR_NONE;
    if (a <= OamHi)                   return WR_MEM;
    if (a >= HramLo && a <= HramHi)   return WR_MEM;
    if (a == AdLcd)                   return WR_LCD;
    if (a == AdScy)                   return WR_SCY;
    if (a == AdScx)                   return WR_SCX;
    if (a == AdDma)                   return WR_DMA;
    if (a >= AdPalLo && a <= AdPalHi) return WR_NONE;
    if (a == AdIf)                    return WR_IF;
    if (a <= IoHi)                    return WR_IO;
    return WR_IE;
  endfunction

endpackage

[rtl/handheld_console_memory_map_core.sv]
// Top level: byte bus decoder with one shared 64 KiB RAM, registers and OAM copy engine.
`timescale 1ns / 1ps

// One beat in, one read_data_o beat out, strobed by valid_o for one cycle; the
// receiver cannot stall. Reads, writes and ROM preloads run in StExec after the
// accepting edge, the strobe follows in the next cycle, and a new beat may be
// accepted at the edge that ends the strobe cycle.
// A write to 0xFF46 holds busy through StExec and then through StDmaRd and StDmaWr
// for each of the 160 OAM bytes: a read then a write of the shared RAM.
// No clearing pass after reset.
module handheld_console_memory_map_core import hcmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  scanline_now_i,
  input  logic [3:0]  direction_keys_i,
  input  logic [3:0]  button_keys_i,
  input  logic [7:0]  random_byte_i,
  output logic        valid_o,
  output logic [7:0]  read_data_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StExec  = 2'd1;
  localparam logic [1:0] StDmaRd = 2'd2;
  localparam logic [1:0] StDmaWr = 2'd3;

  logic [1:0]   state_q, state_d;
  logic [1:0]   req_q;
  logic [15:0]  addr_q;
  logic [7:0]   data_q, line_q, rnd_q;
  logic [3:0]   dirs_q, btns_q;
  logic [7:0]   ix_q, ix_d;
  rgn_e         rgn_q;
  logic [15:0]  raddr_q;
  logic [15:0]  raddr;
  logic [15:0]  dma_src;
  logic [7:0]   lcd_q, scy_q, scx_q, if_q, ie_q, joyp_q;
  logic [IoDepth-1:0] io_vld_q;
  logic         valid_q, fin;
  logic [7:0]   rdata_q, res;
  logic [7:0]   src_byte;
  wr_e          wr_kind;
  logic         exec_wr;
  logic         accept;

  logic [7:0]   mem_q [MemDepth];
  logic [7:0]   mem_rdata_q;
  logic         mem_we;
  logic [15:0]  mem_waddr;
  logic [7:0]   mem_wdata;

  assign accept  = start && (state_q == StIdle);
  assign busy    = (state_q != StIdle);
  assign wr_kind = wr_decode(addr_q);
  assign exec_wr = (state_q == StExec) && (req_q == ReqWrite);
  assign dma_src = {data_q, 8'h00} + {8'h00, ix_q};
  assign raddr   = (state_q == StDmaRd) ? dma_src : address_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[phys_addr(raddr)];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      addr_q <= address_i;
      data_q <= write_data_i;
      line_q <= scanline_now_i;
      dirs_q <= direction_keys_i;
      btns_q <= button_keys_i;
      rnd_q  <= random_byte_i;
    end
    if (accept || state_q == StDmaRd) begin
      rgn_q   <= rd_region(raddr);
      raddr_q <= raddr;
    end
    rdata_q <= res;
  end

  always_comb begin
    unique case (rgn_q)
      RG_MEM:  src_byte = mem_rdata_q;
      RG_IO:   src_byte = io_vld_q[raddr_q[IoIdxW-1:0]] ? mem_rdata_q : 8'h00;
      RG_RND:  src_byte = rnd_q;
      RG_LCD:  src_byte = lcd_q;
      RG_SCY:  src_byte = scy_q;
      RG_SCX:  src_byte = scx_q;
      RG_LINE: src_byte = line_q;
      RG_JOYP: begin
        if (!joyp_q[5])      src_byte = JoypTop | JoypDirs | {4'h0, dirs_q};
        else if (!joyp_q[4]) src_byte = JoypTop | JoypBtns | {4'h0, btns_q};
        else                 src_byte = 8'hFF;
      end
      RG_IF:   src_byte = if_q;
      RG_IE:   src_byte = ie_q;
      default: src_byte = 8'h00;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    ix_d      = ix_q;
    fin       = 1'b0;
    res       = 8'h00;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = data_q;
    unique case (state_q)
      StIdle: begin
        if (start) state_d = StExec;
      end
      StExec: begin
        fin     = 1'b1;
        state_d = StIdle;
        case (req_q)
          ReqRead:    res = src_byte;
          ReqPreload: mem_we = (addr_q <= RomHi);
          ReqWrite: begin
            mem_we = (wr_kind == WR_MEM) || (wr_kind == WR_IO);
            mem_waddr = phys_addr(addr_q);
            if (wr_kind == WR_DMA) begin
              fin     = 1'b0;
              ix_d    = 8'h00;
              state_d = StDmaRd;
            end
          end
          default: ;
        endcase
      end
      StDmaRd: state_d = StDmaWr;
      StDmaWr: begin
        mem_we    = 1'b1;
        mem_waddr = {OamPage, ix_q};
        mem_wdata = src_byte;
        if (ix_q == DmaLast) begin
          fin     = 1'b1;
          state_d = StIdle;
        end else begin
          ix_d    = ix_q + 8'd1;
          state_d = StDmaRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ix_q     <= 8'h00;
      valid_q  <= 1'b0;
      lcd_q    <= 8'h00;
      scy_q    <= 8'h00;
      scx_q    <= 8'h00;
      if_q     <= 8'h00;
      ie_q     <= 8'h00;
      joyp_q   <= 8'h00;
      io_vld_q <= '0;
    end else begin
      state_q <= state_d;
      ix_q    <= ix_d;
      valid_q <= fin;
      if (exec_wr) begin
        case (wr_kind)
          WR_LCD: lcd_q <= data_q;
          WR_SCY: scy_q <= data_q;
          WR_SCX: scx_q <= data_q;
          WR_IF:  if_q  <= data_q;
          WR_IE:  ie_q  <= data_q;
          WR_IO: begin
            io_vld_q[addr_q[IoIdxW-1:0]] <= 1'b1;
            if (addr_q == AdJoyp) joyp_q <= data_q;
          end
          default: ;
        endcase
      end
    end
  end

  assign valid_o     = valid_q;
  assign read_data_o = rdata_q;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("accepted beat did not raise busy");

  a_dma_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDmaWr) |-> ($past(state_q) == StDmaRd))
    else $error("OAM write without its source read");

  a_rom_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && !(state_q == StExec && req_q == ReqPreload)) |-> mem_waddr[15])
    else $error("bus write reached ROM");

endmodule
